>>> hw/rtl/vbs_pkg.sv
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared sizes, register indexes, reset values and helpers for the ViBe
// grayscale background subtractor.
// ----------------------------------------------------------------------------
package vbs_pkg;

    // storage geometry
    localparam int NUM_SAMPLES = 16;
    localparam int FRAME_ROWS  = 128;
    localparam int FRAME_COLS  = 128;

    localparam int ROW_W  = $clog2(FRAME_ROWS);
    localparam int COL_W  = $clog2(FRAME_COLS);
    localparam int ADDR_W = $clog2(FRAME_ROWS * FRAME_COLS);

    // signed width for neighbor positions and frame bounds
    localparam int POS_MAX = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int POS_W   = ((POS_MAX > 8) ? POS_MAX : 8) + 2;

    localparam int SAMPLE_W   = 8;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // operation codes
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_MATCHES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_RATE_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS        = 3'd5;

    // register reset values
    localparam logic [4:0] RST_SAMPLE_COUNT      = 5'd15;
    localparam logic [4:0] RST_REQUIRED_MATCHES  = 5'd7;
    localparam logic [7:0] RST_MATCH_RADIUS      = 8'd20;
    localparam logic [2:0] RST_UPDATE_RATE_SHIFT = 3'd2;
    localparam logic [7:0] RST_FRAME_ROWS        = 8'd128;
    localparam logic [7:0] RST_FRAME_COLS        = 8'd128;

    typedef struct packed {
        logic [4:0] sample_count;
        logic [4:0] required_matches;
        logic [7:0] match_radius;
        logic [2:0] update_rate_shift;
        logic [7:0] frame_rows;
        logic [7:0] frame_cols;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic             background;
    } class_t;

    typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_row_t;

    function automatic logic [ADDR_W-1:0] pixel_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        return ADDR_W'(r) * ADDR_W'(FRAME_COLS) + ADDR_W'(c);
    endfunction

    function automatic logic in_storage(
        input logic signed [POS_W-1:0] r,
        input logic signed [POS_W-1:0] c
    );
        return (r >= 0) && (c >= 0) &&
               (r < $signed(POS_W'(FRAME_ROWS))) && (c < $signed(POS_W'(FRAME_COLS)));
    endfunction

    function automatic logic in_frame(
        input logic signed [POS_W-1:0] r,
        input logic signed [POS_W-1:0] c,
        input cfg_t                    cfg
    );
        return in_storage(r, c) &&
               (r < $signed(POS_W'(cfg.frame_rows))) &&
               (c < $signed(POS_W'(cfg.frame_cols)));
    endfunction

    // update fires when the low shift bits of the draw are all zero
    function automatic logic roll_passes(
        input logic [7:0] roll,
        input logic [2:0] shift
    );
        logic [7:0] mask;
        mask = 8'((9'd1 << shift) - 9'd1);
        return (roll & mask) == 8'd0;
    endfunction

endpackage

>>> hw/rtl/vbs_ram.sv
// ----------------------------------------------------------------------------
// vbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on contents.
// ----------------------------------------------------------------------------
module vbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/vbs_classify.sv
// ----------------------------------------------------------------------------
// vbs_classify
// Compares a pixel value against its sample row and decides background.
// ----------------------------------------------------------------------------
module vbs_classify (
    input  vbs_pkg::sample_row_t            samples,
    input  logic                            stored,
    input  logic [vbs_pkg::SAMPLE_W-1:0]    value,
    input  logic [vbs_pkg::CNT_W-1:0]       used,
    input  vbs_pkg::cfg_t                   cfg,
    output vbs_pkg::class_t                 result
);

    logic [vbs_pkg::NUM_SAMPLES-1:0] hit;
    logic [vbs_pkg::CNT_W-1:0]       total;

    always_comb
    begin
        for (int k = 0; k < vbs_pkg::NUM_SAMPLES; k++)
        begin
            logic [vbs_pkg::SAMPLE_W-1:0] s;
            logic [vbs_pkg::SAMPLE_W-1:0] d;
            s = stored ? samples[k] : '0;
            d = (value > s) ? (value - s) : (s - value);
            hit[k] = (k < int'(used)) && (d < cfg.match_radius);
        end
    end

    // early stop in slot order equals the total capped at the requirement
    assign total = vbs_pkg::CNT_W'($countones(hit));
    assign result.match_count = (total > cfg.required_matches) ? cfg.required_matches : total;
    assign result.background  = !(result.match_count < cfg.required_matches);

endmodule

>>> hw/rtl/vibe_background_subtraction.sv
// ----------------------------------------------------------------------------
// vibe_background_subtraction
// ViBe grayscale background subtractor with a per-pixel sample store held in
// one RAM bank per sample slot.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  in        in_valid/in_ready    operation, pixel position, value, draws, slots
//  out       out_valid/out_ready  foreground_value, flags, match_count
//  cfg       cfg_we               cfg_index, cfg_data (write only)
//
//  The request reads the whole sample row (all banks at one address), and
//  the next cycle classifies and writes back. When the own and the neighbor
//  write hit the same slot bank at different pixels, the neighbor write is
//  held in a register and done from the ST_NB state.
//  The sample store is undefined after reset; no clearing pass is run.
//  A request is taken only when the output register is empty or is being
//  emptied in the same cycle, so a stalled output holds the input side.
//
module vibe_background_subtraction (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [vbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vbs_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [6:0]                          pixel_row,
    input  logic [6:0]                          pixel_col,
    input  logic [7:0]                          pixel_value,
    input  logic [7:0]                          self_update_roll,
    input  logic [7:0]                          neighbor_update_roll,
    input  logic [3:0]                          self_slot,
    input  logic [3:0]                          neighbor_slot,
    input  logic signed [1:0]                   neighbor_row_offset,
    input  logic signed [1:0]                   neighbor_col_offset,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          foreground_value,
    output logic                                is_foreground,
    output logic [4:0]                          match_count,
    output logic                                self_updated,
    output logic                                neighbor_updated
);

    localparam int NS = vbs_pkg::NUM_SAMPLES;
    localparam int AW = vbs_pkg::ADDR_W;
    localparam int PW = vbs_pkg::POS_W;

    // sequencer: accept -> evaluate -> (optional deferred neighbor write)
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_NB   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // configuration registers
    vbs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count      <= vbs_pkg::RST_SAMPLE_COUNT;
            cfg_reg.required_matches  <= vbs_pkg::RST_REQUIRED_MATCHES;
            cfg_reg.match_radius      <= vbs_pkg::RST_MATCH_RADIUS;
            cfg_reg.update_rate_shift <= vbs_pkg::RST_UPDATE_RATE_SHIFT;
            cfg_reg.frame_rows        <= vbs_pkg::RST_FRAME_ROWS;
            cfg_reg.frame_cols        <= vbs_pkg::RST_FRAME_COLS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vbs_pkg::REG_SAMPLE_COUNT:      cfg_reg.sample_count      <= cfg_data[4:0];
                vbs_pkg::REG_REQUIRED_MATCHES:  cfg_reg.required_matches  <= cfg_data[4:0];
                vbs_pkg::REG_MATCH_RADIUS:      cfg_reg.match_radius      <= cfg_data;
                vbs_pkg::REG_UPDATE_RATE_SHIFT: cfg_reg.update_rate_shift <= cfg_data[2:0];
                vbs_pkg::REG_FRAME_ROWS:        cfg_reg.frame_rows        <= cfg_data;
                vbs_pkg::REG_FRAME_COLS:        cfg_reg.frame_cols        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input request capture
    logic                in_accept;
    logic                op_reg;
    logic [6:0]          row_reg;
    logic [6:0]          col_reg;
    logic [7:0]          value_reg;
    logic [7:0]          sroll_reg;
    logic [7:0]          nroll_reg;
    logic [3:0]          sslot_reg;
    logic [3:0]          nslot_reg;
    logic signed [1:0]   roff_reg;
    logic signed [1:0]   coff_reg;

    logic                out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= operation;
            row_reg   <= pixel_row;
            col_reg   <= pixel_col;
            value_reg <= pixel_value;
            sroll_reg <= self_update_roll;
            nroll_reg <= neighbor_update_roll;
            sslot_reg <= self_slot;
            nslot_reg <= neighbor_slot;
            roff_reg  <= neighbor_row_offset;
            coff_reg  <= neighbor_col_offset;
        end
    end

    // sample store: one bank per slot, all read at the pixel's address
    logic [AW-1:0]         rd_addr;
    logic [NS-1:0]         bank_we;
    logic [AW-1:0]         bank_waddr [NS];
    vbs_pkg::sample_row_t  samples;

    assign rd_addr = vbs_pkg::pixel_addr(vbs_pkg::ROW_W'(pixel_row),
                                         vbs_pkg::COL_W'(pixel_col));

    for (genvar b = 0; b < NS; b++)
    begin : g_bank
        vbs_ram #(
            .WIDTH (vbs_pkg::SAMPLE_W),
            .DEPTH (vbs_pkg::FRAME_ROWS * vbs_pkg::FRAME_COLS)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_we[b]),
            .wr_addr (bank_waddr[b]),
            .wr_data (value_reg),
            .rd_en   (in_accept),
            .rd_addr (rd_addr),
            .rd_data (samples[b])
        );
    end

    // evaluate stage
    logic [vbs_pkg::CNT_W-1:0] used;
    logic signed [PW-1:0]      row_s;
    logic signed [PW-1:0]      col_s;
    logic signed [PW-1:0]      nrow_s;
    logic signed [PW-1:0]      ncol_s;
    logic                      stored;
    logic                      self_slot_ok;
    logic                      nb_slot_ok;
    logic [AW-1:0]             self_addr;
    logic [AW-1:0]             nb_addr;
    vbs_pkg::class_t           cls;
    logic                      is_classify;
    logic                      self_wr;
    logic                      nb_wr;
    logic                      eval_self;
    logic                      eval_nb;
    logic                      bank_clash;
    logic                      nb_now;

    assign used = (int'(cfg_reg.sample_count) > NS) ? vbs_pkg::CNT_W'(NS)
                                                     : cfg_reg.sample_count;

    assign row_s  = $signed(PW'(row_reg));
    assign col_s  = $signed(PW'(col_reg));
    assign nrow_s = row_s + PW'(roff_reg);
    assign ncol_s = col_s + PW'(coff_reg);

    assign stored       = vbs_pkg::in_storage(row_s, col_s);
    assign self_slot_ok = {1'b0, sslot_reg} < used;
    assign nb_slot_ok   = {1'b0, nslot_reg} < used;

    assign self_addr = vbs_pkg::pixel_addr(vbs_pkg::ROW_W'(row_reg), vbs_pkg::COL_W'(col_reg));
    assign nb_addr   = vbs_pkg::pixel_addr(nrow_s[vbs_pkg::ROW_W-1:0],
                                           ncol_s[vbs_pkg::COL_W-1:0]);

    vbs_classify u_classify (
        .samples (samples),
        .stored  (stored),
        .value   (value_reg),
        .used    (used),
        .cfg     (cfg_reg),
        .result  (cls)
    );

    assign is_classify = (op_reg == vbs_pkg::OP_CLASSIFY);

    // own write: a load, or a background pixel whose draw passes
    assign self_wr = is_classify
        ? (cls.background && self_slot_ok && vbs_pkg::in_frame(row_s, col_s, cfg_reg) &&
           vbs_pkg::roll_passes(sroll_reg, cfg_reg.update_rate_shift))
        : (self_slot_ok && stored);

    assign nb_wr = is_classify && cls.background && stored && nb_slot_ok &&
                   vbs_pkg::roll_passes(nroll_reg, cfg_reg.update_rate_shift) &&
                   vbs_pkg::in_frame(nrow_s, ncol_s, cfg_reg);

    assign eval_self = (state_reg == ST_EVAL) && self_wr;
    assign eval_nb   = (state_reg == ST_EVAL) && nb_wr;

    // both writes carry the same value, so only a same-bank, different-pixel
    // pair needs the deferred ST_NB write
    assign bank_clash = eval_self && eval_nb && (sslot_reg == nslot_reg) &&
                        (self_addr != nb_addr);
    assign nb_now     = eval_nb && !bank_clash;

    logic [AW-1:0] nb_addr_reg;
    logic [3:0]    nb_slot_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            nb_addr_reg <= nb_addr;
            nb_slot_reg <= nslot_reg;
        end
    end

    always_comb
    begin
        for (int b = 0; b < NS; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = self_addr;
            if (eval_self && (int'(sslot_reg) == b))
            begin
                bank_we[b] = 1'b1;
            end
            if (nb_now && (int'(nslot_reg) == b))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = nb_addr;
            end
            if ((state_reg == ST_NB) && (int'(nb_slot_reg) == b))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = nb_addr_reg;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = bank_clash ? ST_NB : ST_IDLE;
            end
            ST_NB:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register; always free when the evaluate cycle loads it
    logic       out_valid_next;
    logic [7:0] fg_value_reg;
    logic       fg_reg;
    logic [4:0] count_reg;
    logic       self_upd_reg;
    logic       nb_upd_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_EVAL)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            fg_reg       <= is_classify && !cls.background;
            fg_value_reg <= (is_classify && !cls.background) ? value_reg : 8'd0;
            count_reg    <= is_classify ? cls.match_count : 5'd0;
            self_upd_reg <= self_wr;
            nb_upd_reg   <= nb_wr;
        end
    end

    assign out_valid        = out_valid_reg;
    assign foreground_value = fg_value_reg;
    assign is_foreground    = fg_reg;
    assign match_count      = count_reg;
    assign self_updated     = self_upd_reg;
    assign neighbor_updated = nb_upd_reg;

`ifndef SYNTHESIS
    // an accepted request is evaluated in the very next cycle
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_EVAL))
        else $error("request not evaluated after accept");

    // the store is never written while a row read can be in flight
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (bank_we == '0))
        else $error("sample store written while idle");

    // a result appears only from the evaluate cycle
    a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EVAL))
        else $error("result raised outside evaluate");

    // the evaluate cycle never finds the output register still occupied
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> !out_valid_reg)
        else $error("result overwritten before taken");
`endif

endmodule

>>> dv/vibe_background_subtraction_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vibe_background_subtraction_test
// Self-checking bench for the ViBe grayscale subtractor. Seeds two corner
// pixel regions with loads, then drives directed and random classify and
// load requests under several register settings. A scoreboard keeps its own
// copy of the sample store and predicts every result.
// ----------------------------------------------------------------------------
module vibe_background_subtraction_test;

    localparam int STORE_DEPTH    = vbs_pkg::NUM_SAMPLES * vbs_pkg::FRAME_ROWS *
                                    vbs_pkg::FRAME_COLS;
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles with no handshake at all
    localparam int NEAR_JITTER    = 12;    // spread of values aimed at a stored sample

    // one input request, same fields as the input ports
    typedef struct packed {
        logic       operation;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] value;
        logic [7:0] self_roll;
        logic [7:0] neighbor_roll;
        logic [3:0] self_slot;
        logic [3:0] neighbor_slot;
        logic [1:0] row_off;
        logic [1:0] col_off;
    } pixel_req_t;

    // one result, same fields as the output ports
    typedef struct packed {
        logic [7:0] foreground_value;
        logic       is_foreground;
        logic [4:0] match_count;
        logic       self_updated;
        logic       neighbor_updated;
    } pixel_res_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow registers, shadow sample store, expected results
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        vbs_pkg::cfg_t cfg;
        logic [7:0]    bg_samples [0:STORE_DEPTH-1];
        pixel_res_t    expected_pixels [$];
        int            errors;

        function new();
            cfg.sample_count      = vbs_pkg::RST_SAMPLE_COUNT;
            cfg.required_matches  = vbs_pkg::RST_REQUIRED_MATCHES;
            cfg.match_radius      = vbs_pkg::RST_MATCH_RADIUS;
            cfg.update_rate_shift = vbs_pkg::RST_UPDATE_RATE_SHIFT;
            cfg.frame_rows        = vbs_pkg::RST_FRAME_ROWS;
            cfg.frame_cols        = vbs_pkg::RST_FRAME_COLS;
            errors = 0;
        endfunction

        function int slot_index(int r, int c, int slot);
            return (r * vbs_pkg::FRAME_COLS + c) * vbs_pkg::NUM_SAMPLES + slot;
        endfunction

        function void set_reg(logic [vbs_pkg::CFG_IDX_W-1:0] idx,
                              logic [vbs_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                vbs_pkg::REG_SAMPLE_COUNT:      cfg.sample_count      = val[4:0];
                vbs_pkg::REG_REQUIRED_MATCHES:  cfg.required_matches  = val[4:0];
                vbs_pkg::REG_MATCH_RADIUS:      cfg.match_radius      = val;
                vbs_pkg::REG_UPDATE_RATE_SHIFT: cfg.update_rate_shift = val[2:0];
                vbs_pkg::REG_FRAME_ROWS:        cfg.frame_rows        = val;
                vbs_pkg::REG_FRAME_COLS:        cfg.frame_cols        = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function bit update_drawn(logic [7:0] roll);
            return (int'(roll) & ((1 << cfg.update_rate_shift) - 1)) == 0;
        endfunction

        // writes land only inside storage and inside the configured frame
        function bit writable_at(int r, int c);
            return r >= 0 && c >= 0 && r < vbs_pkg::FRAME_ROWS && c < vbs_pkg::FRAME_COLS &&
                   r < int'(cfg.frame_rows) && c < int'(cfg.frame_cols);
        endfunction

        // classify or load one pixel; updates the shadow store
        function pixel_res_t subtract_background(pixel_req_t q);
            pixel_res_t res;
            int         used;
            int         k;
            int         gap;
            int         nr;
            int         nc;
            logic [7:0] s;
            res  = '0;
            used = (int'(cfg.sample_count) > vbs_pkg::NUM_SAMPLES) ? vbs_pkg::NUM_SAMPLES
                                                                   : int'(cfg.sample_count);
            // a 7-bit position is always inside the 128x128 storage
            if (q.operation == vbs_pkg::OP_LOAD) begin
                if (int'(q.self_slot) < used) begin
                    bg_samples[slot_index(q.row, q.col, q.self_slot)] = q.value;
                    res.self_updated = 1'b1;
                end
            end else begin
                k = 0;
                while (res.match_count < cfg.required_matches && k < used) begin
                    s   = bg_samples[slot_index(q.row, q.col, k)];
                    gap = (q.value > s) ? int'(q.value - s) : int'(s - q.value);
                    if (gap < int'(cfg.match_radius))
                        res.match_count = res.match_count + 5'd1;
                    k++;
                end
                if (res.match_count < cfg.required_matches) begin
                    res.is_foreground    = 1'b1;
                    res.foreground_value = q.value;
                end else begin
                    if (update_drawn(q.self_roll) && int'(q.self_slot) < used &&
                        writable_at(q.row, q.col)) begin
                        bg_samples[slot_index(q.row, q.col, q.self_slot)] = q.value;
                        res.self_updated = 1'b1;
                    end
                    if (update_drawn(q.neighbor_roll)) begin
                        nr = int'(q.row) + int'($signed(q.row_off));
                        nc = int'(q.col) + int'($signed(q.col_off));
                        if (int'(q.neighbor_slot) < used && writable_at(nr, nc)) begin
                            bg_samples[slot_index(nr, nc, q.neighbor_slot)] = q.value;
                            res.neighbor_updated = 1'b1;
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_request(pixel_req_t q);
            expected_pixels.insert(expected_pixels.size(), subtract_background(q));
        endfunction

        function void check_field(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(pixel_res_t got);
            pixel_res_t want;
            if (expected_pixels.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            check_field("foreground_value", want.foreground_value, got.foreground_value);
            check_field("is_foreground", want.is_foreground, got.is_foreground);
            check_field("match_count", want.match_count, got.match_count);
            check_field("self_updated", want.self_updated, got.self_updated);
            check_field("neighbor_updated", want.neighbor_updated, got.neighbor_updated);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                           clk;
    logic                           rst_n                = 1'b0;
    logic                           cfg_we               = 1'b0;
    logic [vbs_pkg::CFG_IDX_W-1:0]  cfg_index            = '0;
    logic [vbs_pkg::CFG_DATA_W-1:0] cfg_data             = '0;
    logic                           in_valid             = 1'b0;
    logic                           in_ready;
    logic                           operation            = vbs_pkg::OP_CLASSIFY;
    logic [6:0]                     pixel_row            = '0;
    logic [6:0]                     pixel_col            = '0;
    logic [7:0]                     pixel_value          = '0;
    logic [7:0]                     self_update_roll     = '0;
    logic [7:0]                     neighbor_update_roll = '0;
    logic [3:0]                     self_slot            = '0;
    logic [3:0]                     neighbor_slot        = '0;
    logic signed [1:0]              neighbor_row_offset  = '0;
    logic signed [1:0]              neighbor_col_offset  = '0;
    logic                           out_valid;
    logic                           out_ready            = 1'b0;
    logic [7:0]                     foreground_value;
    logic                           is_foreground;
    logic [4:0]                     match_count;
    logic                           self_updated;
    logic                           neighbor_updated;

    pixel_scoreboard sb;
    bit              steady = 1'b0;  // set: neither side idles
    pixel_res_t      seen;

    vibe_background_subtraction i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .operation            (operation),
        .pixel_row            (pixel_row),
        .pixel_col            (pixel_col),
        .pixel_value          (pixel_value),
        .self_update_roll     (self_update_roll),
        .neighbor_update_roll (neighbor_update_roll),
        .self_slot            (self_slot),
        .neighbor_slot        (neighbor_slot),
        .neighbor_row_offset  (neighbor_row_offset),
        .neighbor_col_offset  (neighbor_col_offset),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .foreground_value     (foreground_value),
        .is_foreground        (is_foreground),
        .match_count          (match_count),
        .self_updated         (self_updated),
        .neighbor_updated     (neighbor_updated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: back-pressure about 23% of cycles unless in a steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 23);
    end

    // Result monitor: values read right after the edge are the sampled ones.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            seen.foreground_value = foreground_value;
            seen.is_foreground    = is_foreground;
            seen.match_count      = match_count;
            seen.self_updated     = self_updated;
            seen.neighbor_updated = neighbor_updated;
            sb.check_result(seen);
        end
    end

    // Watchdog: too long with no handshake on either channel means a hang.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 23);
    endfunction

    // Valid is left high after acceptance; the next request or a drain lowers
    // or reuses it, so valid never gets two assignments in one step.
    task automatic send_request(pixel_req_t q);
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid             <= 1'b1;
        operation            <= q.operation;
        pixel_row            <= q.row;
        pixel_col            <= q.col;
        pixel_value          <= q.value;
        self_update_roll     <= q.self_roll;
        neighbor_update_roll <= q.neighbor_roll;
        self_slot            <= q.self_slot;
        neighbor_slot        <= q.neighbor_slot;
        neighbor_row_offset  <= q.row_off;
        neighbor_col_offset  <= q.col_off;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(q);
    endtask

    // Stop sending and wait until every request has produced its result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [vbs_pkg::CFG_IDX_W-1:0] idx,
                             logic [vbs_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Registers change only with the pipe empty; a spare wait after the drain
    // covers an item that still occupies the block once its result is out.
    task automatic reconfigure(vbs_pkg::cfg_t c);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(vbs_pkg::REG_SAMPLE_COUNT, vbs_pkg::CFG_DATA_W'(c.sample_count));
        write_reg(vbs_pkg::REG_REQUIRED_MATCHES, vbs_pkg::CFG_DATA_W'(c.required_matches));
        write_reg(vbs_pkg::REG_MATCH_RADIUS, c.match_radius);
        write_reg(vbs_pkg::REG_UPDATE_RATE_SHIFT, vbs_pkg::CFG_DATA_W'(c.update_rate_shift));
        write_reg(vbs_pkg::REG_FRAME_ROWS, c.frame_rows);
        write_reg(vbs_pkg::REG_FRAME_COLS, c.frame_cols);
        cfg_we <= 1'b0;
    endtask

    function automatic vbs_pkg::cfg_t make_cfg(int sc, int rm, int rad, int sh, int fr,
                                               int fc);
        vbs_pkg::cfg_t c;
        c.sample_count      = 5'(sc);
        c.required_matches  = 5'(rm);
        c.match_radius      = 8'(rad);
        c.update_rate_shift = 3'(sh);
        c.frame_rows        = 8'(fr);
        c.frame_cols        = 8'(fc);
        return c;
    endfunction

    function automatic logic [7:0] clip8(int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic logic [7:0] sample_at(int r, int c, int k);
        return sb.bg_samples[sb.slot_index(r, c, k)];
    endfunction

    // Seeded pixels: a 4x4 block at each of two opposite corners. Only these
    // are ever classified, since every slot of them has been written.
    function automatic void seeded_pixel(int idx, output int r, output int c);
        r = (idx < 16) ? idx / 4 : 124 + (idx - 16) / 4;
        c = (idx < 16) ? idx % 4 : 124 + (idx - 16) % 4;
    endfunction

    // Request with both draws passing, slot 0 and the pixel itself as neighbor.
    function automatic pixel_req_t plain_req(logic op, int r, int c, int v);
        pixel_req_t q;
        q           = '0;
        q.operation = op;
        q.row       = 7'(r);
        q.col       = 7'(c);
        q.value     = clip8(v);
        return q;
    endfunction

    // Random request: mostly classifies aimed near a stored sample so the
    // background and update paths are reached, plus far values and loads.
    function automatic pixel_req_t draw_request();
        pixel_req_t q;
        int         kind;
        int         r;
        int         c;
        int         mask;
        seeded_pixel($urandom_range(0, 31), r, c);
        kind = $urandom_range(0, 99);
        mask = (1 << sb.cfg.update_rate_shift) - 1;
        if (kind < 15) begin
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 127);
                c = $urandom_range(0, 127);
            end
            q = plain_req(vbs_pkg::OP_LOAD, r, c, $urandom_range(0, 255));
        end else if (kind < 27) begin
            q = plain_req(vbs_pkg::OP_CLASSIFY, r, c, $urandom_range(0, 255));
        end else begin
            q = plain_req(vbs_pkg::OP_CLASSIFY, r, c,
                          int'(sample_at(r, c, $urandom_range(0, 15))) +
                          $urandom_range(0, 2 * NEAR_JITTER) - NEAR_JITTER);
        end
        q.self_roll     = 8'($urandom_range(0, 255));
        q.neighbor_roll = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1))
            q.self_roll = q.self_roll & ~8'(mask);
        if ($urandom_range(0, 1))
            q.neighbor_roll = q.neighbor_roll & ~8'(mask);
        q.self_slot     = 4'($urandom_range(0, 15));
        q.neighbor_slot = 4'($urandom_range(0, 15));
        q.row_off       = 2'($urandom_range(0, 3));  // 2'b10 gives -2
        q.col_off       = 2'($urandom_range(0, 3));
        return q;
    endfunction

    task automatic run_phase(vbs_pkg::cfg_t c, int n, bit no_idle);
        reconfigure(c);
        steady = no_idle;
        repeat (n)
            send_request(draw_request());
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        pixel_req_t    q;
        vbs_pkg::cfg_t d;
        int            r;
        int            c;
        int            base;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Seed: all 16 slots of every seeded pixel, values clustered per pixel.
        d = make_cfg(16, 7, 20, 2, 128, 128);
        reconfigure(d);
        for (int idx = 0; idx < 32; idx++) begin
            seeded_pixel(idx, r, c);
            base = $urandom_range(0, 255);
            for (int k = 0; k < vbs_pkg::NUM_SAMPLES; k++) begin
                q = draw_request();
                q.operation = vbs_pkg::OP_LOAD;
                q.row       = 7'(r);
                q.col       = 7'(c);
                q.self_slot = 4'(k);
                q.value     = clip8(base + $urandom_range(0, 20) - 10);
                send_request(q);
            end
        end

        // Directed: neighbor off the top-left corner of storage
        q = plain_req(vbs_pkg::OP_CLASSIFY, 0, 0, sample_at(0, 0, 0));
        q.self_slot = 4'd15; q.neighbor_slot = 4'd15; q.row_off = 2'b11; q.col_off = 2'b11;
        send_request(q);
        // neighbor off the bottom-right corner of storage
        q = plain_req(vbs_pkg::OP_CLASSIFY, 127, 127, sample_at(127, 127, 3));
        q.row_off = 2'b01; q.col_off = 2'b01;
        send_request(q);
        // offset pattern 2'b10 reaches two rows and columns back
        q = plain_req(vbs_pkg::OP_CLASSIFY, 2, 2, sample_at(2, 2, 1));
        q.row_off = 2'b10; q.col_off = 2'b10; q.neighbor_slot = 4'd7;
        send_request(q);
        // far value: foreground
        send_request(plain_req(vbs_pkg::OP_CLASSIFY, 125, 126,
                               sample_at(125, 126, 0) ^ 8'h80));
        send_request(plain_req(vbs_pkg::OP_CLASSIFY, 1, 1, 0));
        send_request(plain_req(vbs_pkg::OP_CLASSIFY, 1, 1, 255));
        // draws with low bits set: no update
        q = plain_req(vbs_pkg::OP_CLASSIFY, 0, 3, sample_at(0, 3, 2));
        q.self_roll = 8'hff; q.neighbor_roll = 8'h03;
        send_request(q);
        send_request(plain_req(vbs_pkg::OP_LOAD, 100, 50, 255));
        q = plain_req(vbs_pkg::OP_LOAD, 3, 3, 0);
        q.self_slot = 4'd15;
        send_request(q);

        // sample count above storage is clamped
        d.sample_count = 5'd31;
        reconfigure(d);
        q = plain_req(vbs_pkg::OP_CLASSIFY, 0, 1, sample_at(0, 1, 15));
        q.self_slot = 4'd15;
        send_request(q);

        // slots above the samples in use are never written
        d.sample_count = 5'd4;
        reconfigure(d);
        q = plain_req(vbs_pkg::OP_CLASSIFY, 1, 0, sample_at(1, 0, 0));
        q.self_slot = 4'd9; q.neighbor_slot = 4'd12;
        send_request(q);
        q = plain_req(vbs_pkg::OP_LOAD, 1, 0, 77);
        q.self_slot = 4'd10;
        send_request(q);

        // no samples in use: nothing compared
        d.sample_count = 5'd0;
        reconfigure(d);
        send_request(plain_req(vbs_pkg::OP_CLASSIFY, 1, 2, sample_at(1, 2, 0)));

        // zero required matches: always background
        d.sample_count = 5'd16; d.required_matches = 5'd0;
        reconfigure(d);
        send_request(plain_req(vbs_pkg::OP_CLASSIFY, 2, 1, 200));

        // zero radius: nothing matches, even an exact value
        d.required_matches = 5'd7; d.match_radius = 8'd0;
        reconfigure(d);
        send_request(plain_req(vbs_pkg::OP_CLASSIFY, 3, 0, sample_at(3, 0, 0)));

        // small frame: own write outside, neighbor write inside
        d.match_radius = 8'd20; d.frame_rows = 8'd2; d.frame_cols = 8'd2;
        reconfigure(d);
        q = plain_req(vbs_pkg::OP_CLASSIFY, 3, 3, sample_at(3, 3, 1));
        q.row_off = 2'b10; q.col_off = 2'b10;
        send_request(q);

        // Random phases across register settings and their extremes.
        run_phase(make_cfg(16,  7,  20, 2, 128, 128), 180, 1'b0);
        run_phase(make_cfg(31, 16,  40, 0, 255, 255), 180, 1'b0);
        run_phase(make_cfg( 0,  3,  20, 1, 128, 128),  40, 1'b0);
        run_phase(make_cfg( 8,  0,   0, 3,   2,   3), 140, 1'b0);
        run_phase(make_cfg(16, 31, 255, 7,   1,   1),  40, 1'b0);
        run_phase(make_cfg(12,  4,  30, 1, 126, 127), 220, 1'b1);
        run_phase(make_cfg( 1,  1,  10, 0,   0,   0), 100, 1'b0);
        run_phase(make_cfg(15,  7,  20, 2, 128, 128), 180, 1'b0);
        run_phase(make_cfg(16, 16, 255, 0, 128, 128), 190, 1'b0);

        wait_drained();
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
